// ----- hdl/ipdc_pkg.sv -----
// ----------------------------------------------------------------------------
// ipdc_pkg
// Shared types and constants of the instruction pair dependency check:
// request codes, opcode bytes, request and response payloads, control words.
// ----------------------------------------------------------------------------
package ipdc_pkg;

   // request actions
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_LOAD  = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   // control kinds
   localparam logic [1:0] CK_NONE = 2'd0;
   localparam logic [1:0] CK_CALL = 2'd1;

   // effect classes
   localparam logic [2:0] EFF_OPAQUE   = 3'd1;
   localparam logic [2:0] EFF_PURE_RAX = 3'd3;
   localparam logic [2:0] EFF_PURE_RCX = 3'd4;

   // register numbers
   localparam int unsigned REG_RAX = 0;
   localparam int unsigned REG_RCX = 1;
   localparam int unsigned REG_RSP = 4;

   // opcode bytes
   localparam logic [7:0] BYTE_REX_W       = 8'h48;
   localparam logic [7:0] OP_MOV_STORE     = 8'h89;
   localparam logic [7:0] OP_MOV_LOAD      = 8'h8B;
   localparam logic [7:0] MODRM_SIB_NODISP = 8'h04;
   localparam logic [7:0] MODRM_SIB_DISP8  = 8'h44;
   localparam logic [7:0] SIB_RSP_BASE     = 8'h24;
   localparam logic [7:0] OP_PUSH_FIRST    = 8'h50;
   localparam logic [7:0] OP_PUSH_LAST     = 8'h57;
   localparam logic [7:0] OP_POP_FIRST     = 8'h58;
   localparam logic [7:0] OP_POP_LAST      = 8'h5F;

   localparam logic [3:0] LEN_ONE          = 4'd1;
   localparam logic [3:0] LEN_MOV_NODISP   = 4'd4;
   localparam logic [3:0] LEN_MOV_DISP8    = 4'd5;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  first_index;
      logic [7:0]  second_index;
      logic [15:0] regs_read;
      logic [15:0] regs_written;
      logic        flags_read;
      logic        flags_written;
      logic [1:0]  control_kind;
      logic        touches_memory;
      logic [3:0]  byte_length;
      logic [39:0] lead_bytes;
      logic [2:0]  effect_class;
   } req_payload_type;

   typedef struct packed {
      logic       independent;
      logic       accepted;
      logic       any_call;
      logic       any_nonstack_memory;
      logic       aggressive_ok;
      logic [8:0] loaded_count;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_query;
   } dp_status_type;

endpackage

// ----- hdl/ipdc_req_if.sv -----
// ----------------------------------------------------------------------------
// ipdc_req_if
// Request channel: valid/ready handshake with the instruction or query payload.
// ----------------------------------------------------------------------------
interface ipdc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  first_index;
   logic [7:0]  second_index;
   logic [15:0] regs_read;
   logic [15:0] regs_written;
   logic        flags_read;
   logic        flags_written;
   logic [1:0]  control_kind;
   logic        touches_memory;
   logic [3:0]  byte_length;
   logic [39:0] lead_bytes;
   logic [2:0]  effect_class;

   modport source (
      output valid, action, first_index, second_index, regs_read, regs_written,
             flags_read, flags_written, control_kind, touches_memory, byte_length,
             lead_bytes, effect_class,
      input  ready
   );

   modport sink (
      input  valid, action, first_index, second_index, regs_read, regs_written,
             flags_read, flags_written, control_kind, touches_memory, byte_length,
             lead_bytes, effect_class,
      output ready
   );
endinterface

// ----- hdl/ipdc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ipdc_rsp_if
// Response channel: valid/ready handshake with the answer and table status.
// ----------------------------------------------------------------------------
interface ipdc_rsp_if;
   logic       valid;
   logic       ready;
   logic       independent;
   logic       accepted;
   logic       any_call;
   logic       any_nonstack_memory;
   logic       aggressive_ok;
   logic [8:0] loaded_count;

   modport source (
      output valid, independent, accepted, any_call, any_nonstack_memory,
             aggressive_ok, loaded_count,
      input  ready
   );

   modport sink (
      input  valid, independent, accepted, any_call, any_nonstack_memory,
             aggressive_ok, loaded_count,
      output ready
   );
endinterface

// ----- hdl/ipdc_ram.sv -----
// ----------------------------------------------------------------------------
// ipdc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module ipdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]                          rd_data_a,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]                          rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ----- hdl/ipdc_datapath.sv -----
// ----------------------------------------------------------------------------
// ipdc_datapath
// Request register, descriptor builder, descriptor table, pair check,
// table status and response register.
// ----------------------------------------------------------------------------
module ipdc_datapath #(
   parameter int MAX_INSNS = 256,
   parameter int REG_COUNT = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ipdc_pkg::ctrl_cmd_type    cmd,
   output ipdc_pkg::dp_status_type   status,
   input  ipdc_pkg::req_payload_type req_data,
   output ipdc_pkg::rsp_payload_type rsp_data
);

   localparam int AW = (MAX_INSNS > 1) ? $clog2(MAX_INSNS) : 1;
   localparam int CW = $clog2(MAX_INSNS + 1);

   typedef struct packed {
      logic [REG_COUNT-1:0] def_mask;
      logic [REG_COUNT-1:0] use_mask;
      logic                 wr_flags;
      logic                 rd_flags;
      logic                 barrier;
      logic                 stack_only;
      logic                 mem_def;
      logic [7:0]           disp;
   } desc_type;

   localparam int DW = $bits(desc_type);

   ipdc_pkg::req_payload_type req_ff;
   ipdc_pkg::rsp_payload_type rsp_ff;
   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             count_in;
   logic                      saw_call_ff;
   logic                      saw_call_in;
   logic                      saw_nsm_ff;
   logic                      saw_nsm_in;
   logic                      indep_in;
   logic                      acc_in;

   // descriptor builder
   logic [7:0]           b0, b1, b2, b3, b4;
   logic                 mov64, mov_nodisp, mov_disp, is_push, is_pop;
   logic [REG_COUNT-1:0] rsp_bit, op_bit;
   logic                 mem_use, is_call, nonstack;
   desc_type             new_desc;

   // table lookup
   logic [DW-1:0] rd_a, rd_b;
   desc_type      da, db;
   logic          in_range, pair_free, table_room;

   always_comb begin
      b0 = req_ff.lead_bytes[7:0];
      b1 = req_ff.lead_bytes[15:8];
      b2 = req_ff.lead_bytes[23:16];
      b3 = req_ff.lead_bytes[31:24];
      b4 = req_ff.lead_bytes[39:32];
      mov64 = (b0 == ipdc_pkg::BYTE_REX_W) &&
              (b1 == ipdc_pkg::OP_MOV_STORE || b1 == ipdc_pkg::OP_MOV_LOAD) &&
              (b3 == ipdc_pkg::SIB_RSP_BASE);
      mov_nodisp = (req_ff.byte_length >= ipdc_pkg::LEN_MOV_NODISP) && mov64 &&
                   (b2 == ipdc_pkg::MODRM_SIB_NODISP);
      mov_disp   = (req_ff.byte_length >= ipdc_pkg::LEN_MOV_DISP8) && mov64 &&
                   (b2 == ipdc_pkg::MODRM_SIB_DISP8);
      is_push = (req_ff.byte_length == ipdc_pkg::LEN_ONE) &&
                (b0 >= ipdc_pkg::OP_PUSH_FIRST) && (b0 <= ipdc_pkg::OP_PUSH_LAST);
      is_pop  = (req_ff.byte_length == ipdc_pkg::LEN_ONE) &&
                (b0 >= ipdc_pkg::OP_POP_FIRST) && (b0 <= ipdc_pkg::OP_POP_LAST);
      rsp_bit = REG_COUNT'(1) << ipdc_pkg::REG_RSP;
      // push and pop name their register in the low three opcode bits
      op_bit  = REG_COUNT'(1) << b0[2:0];

      new_desc           = '0;
      new_desc.def_mask  = REG_COUNT'(req_ff.regs_written);
      new_desc.use_mask  = REG_COUNT'(req_ff.regs_read);
      new_desc.wr_flags  = req_ff.flags_written;
      new_desc.rd_flags  = req_ff.flags_read;
      new_desc.mem_def   = req_ff.touches_memory;
      mem_use            = req_ff.touches_memory;

      if (mov_nodisp || mov_disp) begin
         new_desc.stack_only = 1'b1;
         new_desc.disp       = mov_disp ? b4 : 8'd0;
         new_desc.mem_def    = (b1 == ipdc_pkg::OP_MOV_STORE);
         mem_use             = (b1 == ipdc_pkg::OP_MOV_LOAD);
      end
      if (is_push) begin
         new_desc.mem_def    = 1'b1;
         new_desc.stack_only = 1'b1;
         new_desc.use_mask   = new_desc.use_mask | op_bit | rsp_bit;
         new_desc.def_mask   = new_desc.def_mask | rsp_bit;
      end
      if (is_pop) begin
         mem_use             = 1'b1;
         new_desc.stack_only = 1'b1;
         new_desc.def_mask   = new_desc.def_mask | op_bit | rsp_bit;
         new_desc.use_mask   = new_desc.use_mask | rsp_bit;
      end
      // pure single-register effects apply only when the lifter gave no masks
      if (new_desc.def_mask == '0 && new_desc.use_mask == '0) begin
         if (req_ff.effect_class == ipdc_pkg::EFF_PURE_RAX) begin
            new_desc.def_mask = REG_COUNT'(1) << ipdc_pkg::REG_RAX;
            new_desc.use_mask = REG_COUNT'(1) << ipdc_pkg::REG_RAX;
         end else if (req_ff.effect_class == ipdc_pkg::EFF_PURE_RCX) begin
            new_desc.def_mask = REG_COUNT'(1) << ipdc_pkg::REG_RCX;
            new_desc.use_mask = REG_COUNT'(1) << ipdc_pkg::REG_RCX;
         end
      end

      is_call  = (req_ff.control_kind == ipdc_pkg::CK_CALL);
      nonstack = (new_desc.mem_def || mem_use) && !new_desc.stack_only;
      new_desc.barrier = (req_ff.control_kind != ipdc_pkg::CK_NONE) ||
                         (req_ff.effect_class == ipdc_pkg::EFF_OPAQUE) || nonstack;
   end

   assign table_room = (count_ff < CW'(MAX_INSNS));

   ipdc_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_INSNS)
   ) u_table (
      .clock     (clock),
      .wr_en     (cmd.commit && req_ff.action == ipdc_pkg::ACT_LOAD && table_room),
      .wr_addr   (count_ff[AW-1:0]),
      .wr_data   (new_desc),
      .rd_addr_a (AW'(req_ff.first_index)),
      .rd_data_a (rd_a),
      .rd_addr_b (AW'(req_ff.second_index)),
      .rd_data_b (rd_b)
   );

   always_comb begin
      da = rd_a;
      db = rd_b;
      in_range = (32'(req_ff.first_index) < 32'(count_ff)) &&
                 (32'(req_ff.second_index) < 32'(count_ff));
      pair_free = !da.barrier && !db.barrier &&
                  !(da.stack_only && db.stack_only && da.disp == db.disp &&
                    (da.mem_def || db.mem_def)) &&
                  ((da.def_mask & db.use_mask) == '0) &&
                  ((db.def_mask & da.use_mask) == '0) &&
                  ((da.def_mask & db.def_mask) == '0) &&
                  !(da.wr_flags && db.rd_flags) &&
                  !(db.wr_flags && da.rd_flags) &&
                  !(da.wr_flags && db.wr_flags);
   end

   always_comb begin
      count_in    = count_ff;
      saw_call_in = saw_call_ff;
      saw_nsm_in  = saw_nsm_ff;
      indep_in    = 1'b0;
      acc_in      = 1'b0;
      case (req_ff.action)
         ipdc_pkg::ACT_START: begin
            count_in    = '0;
            saw_call_in = 1'b0;
            saw_nsm_in  = 1'b0;
            acc_in      = 1'b1;
         end
         ipdc_pkg::ACT_LOAD: begin
            if (table_room) begin
               count_in    = count_ff + CW'(1);
               saw_call_in = saw_call_ff | is_call;
               saw_nsm_in  = saw_nsm_ff | nonstack;
               acc_in      = 1'b1;
            end
         end
         ipdc_pkg::ACT_QUERY: begin
            acc_in   = in_range;
            indep_in = in_range && pair_free;
         end
         default: begin
            acc_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         saw_call_ff <= 1'b0;
         saw_nsm_ff  <= 1'b0;
      end else if (cmd.commit) begin
         count_ff    <= count_in;
         saw_call_ff <= saw_call_in;
         saw_nsm_ff  <= saw_nsm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.commit) begin
         rsp_ff.independent         <= indep_in;
         rsp_ff.accepted            <= acc_in;
         rsp_ff.any_call            <= saw_call_in;
         rsp_ff.any_nonstack_memory <= saw_nsm_in;
         rsp_ff.aggressive_ok       <= (count_in != '0) && !saw_call_in;
         rsp_ff.loaded_count        <= 9'(count_in);
      end
   end

   assign status.is_query = (req_ff.action == ipdc_pkg::ACT_QUERY);
   assign rsp_data        = rsp_ff;

endmodule

// ----- hdl/ipdc_ctrl.sv -----
// ----------------------------------------------------------------------------
// ipdc_ctrl
// Sequencer: takes a request, runs it through the datapath, and owns the
// response valid flag.
// ----------------------------------------------------------------------------
module ipdc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ipdc_pkg::ctrl_cmd_type  cmd,
   input  ipdc_pkg::dp_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOOKUP
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      out_free    = !rsp_valid_ff || rsp_ready;
      cmd.capture = req_valid && req_ready;
      // a query waits in ST_LOOKUP for the registered table read data
      cmd.commit  = out_free &&
                    ((state_ff == ST_EXEC && !status.is_query) ||
                     (state_ff == ST_LOOKUP));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd.capture) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (status.is_query) begin
                  state_ff <= ST_LOOKUP;
               end else if (cmd.commit) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_LOOKUP: begin
               if (cmd.commit) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hdl/instruction_pair_dependency_check.sv -----
// ----------------------------------------------------------------------------
// instruction_pair_dependency_check
// Builds a table of instruction dataflow descriptors and answers whether two
// stored instructions may be reordered.
//
// Usage:
//   req_chan carries one request per valid/ready handshake: start (clear the
//   table), load (append one instruction descriptor) or query (check a pair
//   of slots). rsp_chan returns exactly one response per request: the query
//   answer, an accepted flag and the table status after the request.
//   Start and load responses are registered from the execute state; query
//   responses also pass the registered table read and the lookup state.
//   The sequencer takes a new request only from idle, once the last one has
//   committed its response.
//   A finished response sits in an output register; the next request is
//   taken while it waits. When the receiver stalls, the following request
//   holds in the datapath until the response register frees.
//   Reset empties the table (count and flags cleared); stored descriptors are
//   left as they are and are never read past the count.
// ----------------------------------------------------------------------------
module instruction_pair_dependency_check #(
   parameter int MAX_INSNS = 256,
   parameter int REG_COUNT = 16
) (
   input  logic          clock,
   input  logic          reset,
   ipdc_req_if.sink      req_chan,
   ipdc_rsp_if.source    rsp_chan
);

   ipdc_pkg::ctrl_cmd_type    cmd;
   ipdc_pkg::dp_status_type   status;
   ipdc_pkg::req_payload_type req_data;
   ipdc_pkg::rsp_payload_type rsp_data;

   always_comb begin
      req_data.action         = req_chan.action;
      req_data.first_index    = req_chan.first_index;
      req_data.second_index   = req_chan.second_index;
      req_data.regs_read      = req_chan.regs_read;
      req_data.regs_written   = req_chan.regs_written;
      req_data.flags_read     = req_chan.flags_read;
      req_data.flags_written  = req_chan.flags_written;
      req_data.control_kind   = req_chan.control_kind;
      req_data.touches_memory = req_chan.touches_memory;
      req_data.byte_length    = req_chan.byte_length;
      req_data.lead_bytes     = req_chan.lead_bytes;
      req_data.effect_class   = req_chan.effect_class;
   end

   ipdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   ipdc_datapath #(
      .MAX_INSNS (MAX_INSNS),
      .REG_COUNT (REG_COUNT)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   assign rsp_chan.independent         = rsp_data.independent;
   assign rsp_chan.accepted            = rsp_data.accepted;
   assign rsp_chan.any_call            = rsp_data.any_call;
   assign rsp_chan.any_nonstack_memory = rsp_data.any_nonstack_memory;
   assign rsp_chan.aggressive_ok       = rsp_data.aggressive_ok;
   assign rsp_chan.loaded_count        = rsp_data.loaded_count;

endmodule

// ----- tb/ipdc_dependency_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdc_dependency_monitor
// Watches the request and response channels of the dependency check. Every
// accepted request updates a shadow descriptor table and yields the expected
// response; every accepted response is compared field by field against the
// oldest one waiting.
// ----------------------------------------------------------------------------
module ipdc_dependency_monitor #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   ipdc_req_if         req_chan,
   ipdc_rsp_if         rsp_chan,
   output int unsigned mismatch_count,
   output int unsigned pending_count,
   output int unsigned independent_count
);

   typedef struct packed {
      logic [15:0] def_mask;
      logic [15:0] use_mask;
      logic        wr_flags;
      logic        rd_flags;
      logic        call;
      logic        control;
      logic        mem_def;
      logic        mem_use;
      logic        stack_only;
      logic        opaque;
      logic [7:0]  disp;
   } dataflow_desc_type;

   dataflow_desc_type         desc_table [TABLE_DEPTH];
   int unsigned               table_count;
   logic                      saw_call;
   logic                      saw_nonstack_mem;
   ipdc_pkg::rsp_payload_type answer_q [$];
   int unsigned               fail_total;
   int unsigned               indep_total;

   function automatic dataflow_desc_type lift_descriptor(
      input ipdc_pkg::req_payload_type r);
      dataflow_desc_type d;
      logic [7:0] b0, b1, b2, b3, b4;
      logic       rsp_move;
      b0 = r.lead_bytes[7:0];
      b1 = r.lead_bytes[15:8];
      b2 = r.lead_bytes[23:16];
      b3 = r.lead_bytes[31:24];
      b4 = r.lead_bytes[39:32];
      rsp_move = b0 == ipdc_pkg::BYTE_REX_W &&
                 (b1 == ipdc_pkg::OP_MOV_STORE || b1 == ipdc_pkg::OP_MOV_LOAD) &&
                 b3 == ipdc_pkg::SIB_RSP_BASE;
      d = '0;
      d.def_mask  = r.regs_written;
      d.use_mask  = r.regs_read;
      d.wr_flags  = r.flags_written;
      d.rd_flags  = r.flags_read;
      d.call      = r.control_kind == ipdc_pkg::CK_CALL;
      d.control   = r.control_kind != ipdc_pkg::CK_NONE;
      d.mem_def   = r.touches_memory;
      d.mem_use   = r.touches_memory;
      if (rsp_move && ((b2 == ipdc_pkg::MODRM_SIB_NODISP &&
                        r.byte_length >= ipdc_pkg::LEN_MOV_NODISP) ||
                       (b2 == ipdc_pkg::MODRM_SIB_DISP8 &&
                        r.byte_length >= ipdc_pkg::LEN_MOV_DISP8))) begin
         d.stack_only = 1'b1;
         d.disp       = (b2 == ipdc_pkg::MODRM_SIB_DISP8) ? b4 : 8'h00;
         d.mem_def    = b1 == ipdc_pkg::OP_MOV_STORE;
         d.mem_use    = b1 == ipdc_pkg::OP_MOV_LOAD;
      end
      if (r.byte_length == ipdc_pkg::LEN_ONE && b0 >= ipdc_pkg::OP_PUSH_FIRST &&
          b0 <= ipdc_pkg::OP_PUSH_LAST) begin
         d.mem_def    = 1'b1;
         d.stack_only = 1'b1;
         d.use_mask  |= (16'd1 << (b0 - ipdc_pkg::OP_PUSH_FIRST)) |
                        (16'd1 << ipdc_pkg::REG_RSP);
         d.def_mask  |= 16'd1 << ipdc_pkg::REG_RSP;
      end
      if (r.byte_length == ipdc_pkg::LEN_ONE && b0 >= ipdc_pkg::OP_POP_FIRST &&
          b0 <= ipdc_pkg::OP_POP_LAST) begin
         d.mem_use    = 1'b1;
         d.stack_only = 1'b1;
         d.def_mask  |= (16'd1 << (b0 - ipdc_pkg::OP_POP_FIRST)) |
                        (16'd1 << ipdc_pkg::REG_RSP);
         d.use_mask  |= 16'd1 << ipdc_pkg::REG_RSP;
      end
      d.opaque = r.effect_class == ipdc_pkg::EFF_OPAQUE;
      // pure classes only fill in masks the lifter left empty
      if (d.def_mask == '0 && d.use_mask == '0) begin
         if (r.effect_class == ipdc_pkg::EFF_PURE_RAX) begin
            d.def_mask = 16'd1 << ipdc_pkg::REG_RAX;
            d.use_mask = 16'd1 << ipdc_pkg::REG_RAX;
         end else if (r.effect_class == ipdc_pkg::EFF_PURE_RCX) begin
            d.def_mask = 16'd1 << ipdc_pkg::REG_RCX;
            d.use_mask = 16'd1 << ipdc_pkg::REG_RCX;
         end
      end
      return d;
   endfunction

   function automatic logic pair_independent(input dataflow_desc_type a,
                                              input dataflow_desc_type b);
      if (a.control || b.control || a.call || b.call || a.opaque || b.opaque)
         return 1'b0;
      if ((a.mem_def || a.mem_use) && !a.stack_only)
         return 1'b0;
      if ((b.mem_def || b.mem_use) && !b.stack_only)
         return 1'b0;
      if (a.stack_only && b.stack_only && a.disp == b.disp && (a.mem_def || b.mem_def))
         return 1'b0;
      if ((a.def_mask & b.use_mask) != '0 || (b.def_mask & a.use_mask) != '0 ||
          (a.def_mask & b.def_mask) != '0)
         return 1'b0;
      if ((a.wr_flags && b.rd_flags) || (b.wr_flags && a.rd_flags) ||
          (a.wr_flags && b.wr_flags))
         return 1'b0;
      return 1'b1;
   endfunction

   task automatic apply_request(input ipdc_pkg::req_payload_type r,
                                output ipdc_pkg::rsp_payload_type ans);
      dataflow_desc_type d;
      ans = '0;
      case (r.action)
         ipdc_pkg::ACT_START: begin
            table_count      = 0;
            saw_call         = 1'b0;
            saw_nonstack_mem = 1'b0;
            ans.accepted     = 1'b1;
         end
         ipdc_pkg::ACT_LOAD: begin
            // drop loads into a full table
            if (table_count < TABLE_DEPTH) begin
               d = lift_descriptor(r);
               desc_table[table_count] = d;
               if (d.call)
                  saw_call = 1'b1;
               if ((d.mem_def || d.mem_use) && !d.stack_only)
                  saw_nonstack_mem = 1'b1;
               table_count++;
               ans.accepted = 1'b1;
            end
         end
         ipdc_pkg::ACT_QUERY: begin
            if (r.first_index < table_count && r.second_index < table_count) begin
               ans.accepted    = 1'b1;
               ans.independent = pair_independent(desc_table[r.first_index],
                                                  desc_table[r.second_index]);
            end
         end
         default: begin
         end
      endcase
      ans.any_call            = saw_call;
      ans.any_nonstack_memory = saw_nonstack_mem;
      ans.aggressive_ok       = table_count != 0 && !saw_call;
      ans.loaded_count        = 9'(table_count);
   endtask

   task automatic report_field(input string field, input logic [8:0] want,
                               input logic [8:0] got);
      if (got !== want) begin
         fail_total++;
         if (fail_total <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      ipdc_pkg::req_payload_type req;
      ipdc_pkg::rsp_payload_type got;
      ipdc_pkg::rsp_payload_type want;
      if (reset) begin
         answer_q.delete();
         table_count       = 0;
         saw_call          = 1'b0;
         saw_nonstack_mem  = 1'b0;
         fail_total        = 0;
         indep_total       = 0;
         mismatch_count    <= 0;
         pending_count     <= 0;
         independent_count <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.independent, rsp_chan.accepted, rsp_chan.any_call,
                   rsp_chan.any_nonstack_memory, rsp_chan.aggressive_ok,
                   rsp_chan.loaded_count};
            if (answer_q.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("%0t: response with no request outstanding", $time);
            end else begin
               want = answer_q.pop_front();
               report_field("independent", 9'(want.independent), 9'(got.independent));
               report_field("accepted", 9'(want.accepted), 9'(got.accepted));
               report_field("any_call", 9'(want.any_call), 9'(got.any_call));
               report_field("any_nonstack_memory", 9'(want.any_nonstack_memory),
                            9'(got.any_nonstack_memory));
               report_field("aggressive_ok", 9'(want.aggressive_ok), 9'(got.aggressive_ok));
               report_field("loaded_count", want.loaded_count, got.loaded_count);
               if (want.independent)
                  indep_total++;
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            req = {req_chan.action, req_chan.first_index, req_chan.second_index,
                   req_chan.regs_read, req_chan.regs_written, req_chan.flags_read,
                   req_chan.flags_written, req_chan.control_kind, req_chan.touches_memory,
                   req_chan.byte_length, req_chan.lead_bytes, req_chan.effect_class};
            apply_request(req, want);
            answer_q.push_back(want);
         end
         mismatch_count    <= fail_total;
         pending_count     <= answer_q.size();
         independent_count <= indep_total;
      end
   end

endmodule

// ----- tb/instruction_pair_dependency_check_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// instruction_pair_dependency_check_tb
// Drives start, load, query and reserved requests into the dependency check: a directed
// pass over the stack-move, push/pop, pure-class and barrier cases, then
// random sessions of loads and queries, two of them filling the table past
// capacity. Both channels idle at random; the monitor checks every response.
// ----------------------------------------------------------------------------
module instruction_pair_dependency_check_tb;

   localparam int          TABLE_DEPTH     = 256;
   localparam int unsigned ITEM_TARGET     = 1850;
   localparam int unsigned RSP_HOLD_CYCLES = 300;

   localparam logic [1:0] ACT_RESERVED    = 2'd3;
   localparam logic [1:0] CK_JUMP         = 2'd2;
   localparam logic [1:0] CK_RESERVED     = 2'd3;
   localparam logic [2:0] EFF_OTHER       = 3'd0;
   localparam logic [2:0] EFF_MEMORY      = 3'd2;
   localparam logic [2:0] EFF_RESERVED_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ipdc_req_if req_chan ();
   ipdc_rsp_if rsp_chan ();

   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned independent_count;

   bit          hold_rsp;
   int unsigned nogap_left;
   int unsigned stored;
   int unsigned n_sent, n_start, n_load, n_dropped, n_query, n_hit, n_reserved;

   instruction_pair_dependency_check #(
      .MAX_INSNS(TABLE_DEPTH),
      .REG_COUNT(16)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   ipdc_dependency_monitor #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_monitor (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count),
      .independent_count(independent_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // most idle stretches are short, a few are long
   function automatic int unsigned idle_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      if (r < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] sparse_mask();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return 16'd1 << $urandom_range(0, 15);
         6, 7:             return 16'd0;
         8:                return (16'd1 << $urandom_range(0, 15)) |
                                  (16'd1 << $urandom_range(0, 15));
         default:          return 16'($urandom);
      endcase
   endfunction

   function automatic logic [39:0] rsp_move_bytes(input logic [7:0] opcode,
                                                   input logic [7:0] modrm,
                                                   input logic [7:0] disp);
      return {disp, ipdc_pkg::SIB_RSP_BASE, modrm, opcode, ipdc_pkg::BYTE_REX_W};
   endfunction

   function automatic ipdc_pkg::req_payload_type mk_load(
      input logic [15:0] rd, input logic [15:0] wr, input logic fr, input logic fw,
      input logic [1:0] ck, input logic mem, input logic [3:0] len,
      input logic [39:0] lead, input logic [2:0] eff);
      ipdc_pkg::req_payload_type p;
      p = '0;
      p.action         = ipdc_pkg::ACT_LOAD;
      p.regs_read      = rd;
      p.regs_written   = wr;
      p.flags_read     = fr;
      p.flags_written  = fw;
      p.control_kind   = ck;
      p.touches_memory = mem;
      p.byte_length    = len;
      p.lead_bytes     = lead;
      p.effect_class   = eff;
      return p;
   endfunction

   function automatic ipdc_pkg::req_payload_type mk_request(input logic [1:0] act,
                                                            input logic [7:0] i,
                                                            input logic [7:0] j);
      ipdc_pkg::req_payload_type p;
      p = '0;
      p.action       = act;
      p.first_index  = i;
      p.second_index = j;
      return p;
   endfunction

   function automatic ipdc_pkg::req_payload_type random_load();
      ipdc_pkg::req_payload_type p;
      int unsigned               pick;
      logic [7:0]                disp;
      p = '0;
      p.action         = ipdc_pkg::ACT_LOAD;
      p.first_index    = 8'($urandom);
      p.second_index   = 8'($urandom);
      p.regs_read      = sparse_mask();
      p.regs_written   = sparse_mask();
      p.flags_read     = $urandom_range(0, 3) == 0;
      p.flags_written  = $urandom_range(0, 3) == 0;
      p.control_kind   = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3))
                                                     : ipdc_pkg::CK_NONE;
      p.touches_memory = $urandom_range(0, 3) == 0;
      p.byte_length    = 4'($urandom);
      p.lead_bytes     = {8'($urandom), 32'($urandom)};
      p.effect_class   = $urandom_range(0, 1) ? EFF_OTHER : 3'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         case ($urandom_range(0, 4))
            0:       disp = 8'h00;
            1:       disp = 8'h08;
            2:       disp = 8'h10;
            3:       disp = 8'hF8;
            default: disp = 8'($urandom);
         endcase
         p.lead_bytes  = rsp_move_bytes($urandom_range(0, 1) ? ipdc_pkg::OP_MOV_STORE
                                                             : ipdc_pkg::OP_MOV_LOAD,
                                        $urandom_range(0, 1) ? ipdc_pkg::MODRM_SIB_NODISP
                                                             : ipdc_pkg::MODRM_SIB_DISP8,
                                        disp);
         p.byte_length = 4'($urandom_range(3, 8));
         // break the pattern now and then
         if (pick < 4)
            p.lead_bytes[8 * $urandom_range(0, 3) +: 8] = 8'($urandom);
      end else if (pick < 50) begin
         p.lead_bytes[7:0] = 8'($urandom_range(ipdc_pkg::OP_PUSH_FIRST,
                                               ipdc_pkg::OP_POP_LAST));
         p.byte_length     = ($urandom_range(0, 7) == 0) ? 4'($urandom)
                                                         : ipdc_pkg::LEN_ONE;
      end
      if ($urandom_range(0, 4) == 0) begin
         p.regs_read    = '0;
         p.regs_written = '0;
         p.effect_class = $urandom_range(0, 1) ? ipdc_pkg::EFF_PURE_RAX
                                               : ipdc_pkg::EFF_PURE_RCX;
      end
      return p;
   endfunction

   function automatic ipdc_pkg::req_payload_type random_query(input int unsigned count);
      ipdc_pkg::req_payload_type p;
      p = random_load();
      p.action = ipdc_pkg::ACT_QUERY;
      if (count != 0 && $urandom_range(0, 99) < 85) begin
         p.first_index  = 8'($urandom_range(0, count - 1));
         p.second_index = 8'($urandom_range(0, count - 1));
      end
      return p;
   endfunction

   task automatic put_payload(input ipdc_pkg::req_payload_type p);
      req_chan.action         <= p.action;
      req_chan.first_index    <= p.first_index;
      req_chan.second_index   <= p.second_index;
      req_chan.regs_read      <= p.regs_read;
      req_chan.regs_written   <= p.regs_written;
      req_chan.flags_read     <= p.flags_read;
      req_chan.flags_written  <= p.flags_written;
      req_chan.control_kind   <= p.control_kind;
      req_chan.touches_memory <= p.touches_memory;
      req_chan.byte_length    <= p.byte_length;
      req_chan.lead_bytes     <= p.lead_bytes;
      req_chan.effect_class   <= p.effect_class;
   endtask

   task automatic send(input ipdc_pkg::req_payload_type p);
      int unsigned gap;
      gap = 0;
      if (nogap_left != 0)
         nogap_left--;
      else if ($urandom_range(0, 99) < 45)
         gap = idle_cycles();
      else if ($urandom_range(0, 49) == 0)
         nogap_left = $urandom_range(20, 60);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      put_payload(p);
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      n_sent++;
      case (p.action)
         ipdc_pkg::ACT_START: begin
            stored = 0;
            n_start++;
         end
         ipdc_pkg::ACT_LOAD: begin
            n_load++;
            if (stored < TABLE_DEPTH)
               stored++;
            else
               n_dropped++;
         end
         ipdc_pkg::ACT_QUERY: begin
            n_query++;
            if (p.first_index < stored && p.second_index < stored)
               n_hit++;
         end
         default: n_reserved++;
      endcase
   endtask

   // drop valid and hold until every response is back
   task automatic wait_for_answers();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // response side: random stalls, and one long hold-off on request
   initial begin
      int unsigned run;
      rsp_chan.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         rsp_chan.ready <= 1'b1;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
         repeat (run) @(posedge clock);
         rsp_chan.ready <= 1'b0;
         repeat (idle_cycles()) @(posedge clock);
      end
   end

   initial begin
      int unsigned session;
      int unsigned load_goal;
      hold_rsp   = 1'b0;
      nogap_left = 0;
      stored     = 0;
      n_sent = 0; n_start = 0; n_load = 0; n_dropped = 0;
      n_query = 0; n_hit = 0; n_reserved = 0;
      req_chan.valid <= 1'b0;
      put_payload('0);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: slot numbers in the comments refer to table positions
      send(mk_request(ipdc_pkg::ACT_START, 8'd0, 8'd0));
      send(mk_request(ipdc_pkg::ACT_QUERY, 8'd0, 8'd0));
      send(mk_load(16'h0001, 16'h0000, 1'b0, 1'b0, ipdc_pkg::CK_NONE, 1'b1,
                   ipdc_pkg::LEN_MOV_NODISP,
                   rsp_move_bytes(ipdc_pkg::OP_MOV_STORE, ipdc_pkg::MODRM_SIB_NODISP,
                                  8'h00), EFF_OTHER));                                  // 0
      send(mk_load(16'h0000, 16'h0002, 1'b0, 1'b0, ipdc_pkg::CK_NONE, 1'b0,
                   ipdc_pkg::LEN_MOV_NODISP,
                   rsp_move_bytes(ipdc_pkg::OP_MOV_LOAD, ipdc_pkg::MODRM_SIB_NODISP,
                                  8'h00), EFF_OTHER));                                  // 1
      send(mk_load(16'h0004, 16'h0000, 1'b0, 1'b0, ipdc_pkg::CK_NONE, 1'b1,
                   ipdc_pkg::LEN_MOV_DISP8,
                   rsp_move_bytes(ipdc_pkg::OP_MOV_STORE, ipdc_pkg::MODRM_SIB_DISP8,
                                  8'hF8), EFF_OTHER));                                  // 2
      send(mk_load(16'h0000, 16'h0008, 1'b0, 1'b0, ipdc_pkg::CK_NONE, 1'b1,
                   ipdc_pkg::LEN_MOV_DISP8,
                   rsp_move_bytes(ipdc_pkg::OP_MOV_LOAD, ipdc_pkg::MODRM_SIB_DISP8,
                                  8'h08), EFF_OTHER));                                  // 3
      // too short for a stack move: plain memory access
      send(mk_load(16'h0000, 16'h0000, 1'b0, 1'b0, ipdc_pkg::CK_NONE, 1'b1,
                   ipdc_pkg::LEN_MOV_NODISP - 4'd1,
                   rsp_move_bytes(ipdc_pkg::OP_MOV_STORE, ipdc_pkg::MODRM_SIB_NODISP,
                                  8'h00), EFF_MEMORY));                                 // 4
      send(mk_load('0, '0, 1'b0, 1'b0, ipdc_pkg::CK_NONE, 1'b0, ipdc_pkg::LEN_ONE,
                   {32'd0, ipdc_pkg::OP_PUSH_FIRST}, EFF_OTHER));                       // 5
      send(mk_load('0, '0, 1'b0, 1'b0, ipdc_pkg::CK_NONE, 1'b0, ipdc_pkg::LEN_ONE,
                   {32'd0, ipdc_pkg::OP_POP_LAST}, EFF_OTHER));                         // 6
      send(mk_load('0, '0, 1'b0, 1'b0, ipdc_pkg::CK_NONE, 1'b0, ipdc_pkg::LEN_ONE, '0,
                   ipdc_pkg::EFF_PURE_RAX));                                            // 7
      send(mk_load('0, '0, 1'b0, 1'b0, ipdc_pkg::CK_NONE, 1'b0, ipdc_pkg::LEN_ONE, '0,
                   ipdc_pkg::EFF_PURE_RCX));                                            // 8
      send(mk_load(16'h0100, '0, 1'b0, 1'b0, ipdc_pkg::CK_NONE, 1'b0, ipdc_pkg::LEN_ONE,
                   '0, ipdc_pkg::EFF_OPAQUE));                                          // 9
      send(mk_load('0, 16'h0001, 1'b0, 1'b0, ipdc_pkg::CK_CALL, 1'b0,
                   ipdc_pkg::LEN_MOV_DISP8, '0, EFF_OTHER));                            // 10
      send(mk_load('0, '0, 1'b1, 1'b0, CK_RESERVED, 1'b0, ipdc_pkg::LEN_ONE, '0,
                   EFF_OTHER));                                                         // 11
      send(mk_load('0, 16'h0200, 1'b0, 1'b1, ipdc_pkg::CK_NONE, 1'b0, ipdc_pkg::LEN_ONE,
                   '0, EFF_OTHER));                                                     // 12
      send(mk_load(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, CK_JUMP, 1'b1, 4'hF, {40{1'b1}},
                   EFF_RESERVED_HI));                                                   // 13
      send(mk_request(ipdc_pkg::ACT_QUERY, 8'd0, 8'd1));     // same slot, one store
      send(mk_request(ipdc_pkg::ACT_QUERY, 8'd2, 8'd3));     // different slots
      send(mk_request(ipdc_pkg::ACT_QUERY, 8'd1, 8'd3));     // two loads
      send(mk_request(ipdc_pkg::ACT_QUERY, 8'd5, 8'd6));     // push against pop
      send(mk_request(ipdc_pkg::ACT_QUERY, 8'd7, 8'd8));     // pure rax against pure rcx
      send(mk_request(ipdc_pkg::ACT_QUERY, 8'd11, 8'd12));   // control barrier, flags
      send(mk_request(ipdc_pkg::ACT_QUERY, 8'd255, 8'd0));   // beyond the table
      send(mk_request(ACT_RESERVED, 8'd0, 8'd0));
      send(mk_request(ipdc_pkg::ACT_START, 8'd255, 8'd255));
      wait_for_answers();

      session = 0;
      while (n_sent < ITEM_TARGET) begin
         ipdc_pkg::req_payload_type p;
         if ($urandom_range(0, 19) != 0) begin
            p = random_load();
            p.action = ipdc_pkg::ACT_START;
            send(p);
         end
         if (session == 1 || session == 4)
            load_goal = TABLE_DEPTH + $urandom_range(2, 6);
         else
            load_goal = $urandom_range(1, 24);
         // stall the response side while requests keep coming back to back
         if (session == 1) begin
            hold_rsp   = 1'b1;
            nogap_left = 80;
         end
         for (int unsigned k = 0; k < load_goal; k++) begin
            send(random_load());
            if ($urandom_range(0, 99) < 35)
               send(random_query(stored));
            if ($urandom_range(0, 99) < 2) begin
               p = random_load();
               p.action = ACT_RESERVED;
               send(p);
            end
         end
         repeat ($urandom_range(2, 10)) send(random_query(stored));
         if (session == 3)
            wait_for_answers();
         session++;
      end

      wait_for_answers();
      repeat (10) @(posedge clock);
      $display("covered %0d requests: %0d starts, %0d loads (%0d dropped when full), %0d queries",
               n_sent, n_start, n_load, n_dropped, n_query);
      $display("%0d queries in range, %0d answered independent, %0d reserved actions",
               n_hit, independent_count, n_reserved);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("instruction_pair_dependency_check regression: pass");
      end else begin
         $display("instruction_pair_dependency_check regression: fail");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("timeout waiting for the dependency check");
      $display("instruction_pair_dependency_check regression: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/ipdc_pkg.sv
hdl/ipdc_req_if.sv
hdl/ipdc_rsp_if.sv
hdl/ipdc_ram.sv
hdl/ipdc_datapath.sv
hdl/ipdc_ctrl.sv
hdl/instruction_pair_dependency_check.sv
tb/ipdc_dependency_monitor.sv
tb/instruction_pair_dependency_check_tb.sv
